// ===== rtl/core/xor_checked_packet_deframer_assert.svh =====
// Assertion macros for the xor checked packet deframer.
// Included by the top level; SYNTH removes the checks from synthesis.
`ifndef XOR_CHECKED_PACKET_DEFRAMER_ASSERT_SVH
`define XOR_CHECKED_PACKET_DEFRAMER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define XCPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define XCPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define XCPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define XCPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/xcpd_pkg.sv =====
// Shared types and constants of the xor checked packet deframer.
// No dependencies; used by the frame step and the top level.
package xcpd_pkg;

  localparam int unsigned CONTROL_BYTES = 3;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

  typedef enum logic [0:0] {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    K_PAYLOAD = 3'd0,
    K_OK      = 3'd1,
    K_BAD     = 3'd2,
    K_TIMEOUT = 3'd3,
    K_LENERR  = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_LEN     = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_CHECK   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [0:0] opcode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] frame_command;
    logic [7:0] payload_byte;
    logic [7:0] payload_count;
    logic       frame_end;
  } result_t;

endpackage

// ===== rtl/core/xcpd_in_if.sv =====
// Input item channel of the deframer: valid/ready handshake with byte/tick payload.
// Depends on nothing.
interface xcpd_in_if;
  logic       valid;
  logic       ready;
  logic [0:0] opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

// ===== rtl/core/xcpd_out_if.sv =====
// Result item channel of the deframer: valid/ready handshake with result fields.
// Depends on nothing.
interface xcpd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] frame_command;
  logic [7:0] payload_byte;
  logic [7:0] payload_count;
  logic       frame_end;

  modport source (output valid, output kind, output frame_command, output payload_byte,
                  output payload_count, output frame_end, input ready);
  modport sink   (input valid, input kind, input frame_command, input payload_byte,
                  input payload_count, input frame_end, output ready);
endinterface

// ===== rtl/core/xor_checked_packet_deframer.sv =====
// Top level of the xor checked packet deframer.
// Depends on xcpd_pkg, xcpd_in_if, xcpd_out_if, xcpd_step and the assert header.
//
// Usage:
//   in_ch carries items: opcode 0 is a received byte (rx_byte), opcode 1 a
//   millisecond tick. Frames are command, total length, payload, xor checksum.
//   out_ch carries results: each payload byte, then one closing result per
//   frame (ok, checksum bad, timeout or length error) with frame_end set.
//   cfg_wr_en/cfg_wr_data write timeout_ms (reset 1000); write only while idle.
//   Path: an accepted item is held in the input register; its result then
//   reaches out_ch through the result register.
//   Throughput: one item per cycle while in_ch.ready stays high; the frame
//   state updates as each item leaves the input register.
//   Stall: while a result waits in the output register, the input register
//   still fills; in_ch.ready drops only when the input register holds an item
//   with a result and the output register is full and not being taken.
//   Items without a result pass even then.
//   Reset (synchronous, rst_n low) clears the frame state, empties both
//   registers and sets timeout_ms back to 1000.
`include "xor_checked_packet_deframer_assert.svh"

module xor_checked_packet_deframer
  import xcpd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  xcpd_in_if.sink      in_ch,
  xcpd_out_if.source   out_ch,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data
);

  logic        s1_valid_r;
  item_t       s1_item_r;
  logic        out_valid_r;
  result_t     out_res_r;
  logic [15:0] timeout_r;

  logic        has_res;
  result_t     res;
  logic        out_free;
  logic        advance;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign advance     = s1_valid_r && (!has_res || out_free);
  assign in_ch.ready = !s1_valid_r || advance;

  xcpd_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (advance),
    .item       (s1_item_r),
    .timeout_ms (timeout_r),
    .has_res    (has_res),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r.opcode  <= in_ch.opcode;
      s1_item_r.rx_byte <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && has_res) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = out_res_r.kind;
  assign out_ch.frame_command = out_res_r.frame_command;
  assign out_ch.payload_byte  = out_res_r.payload_byte;
  assign out_ch.payload_count = out_res_r.payload_count;
  assign out_ch.frame_end     = out_res_r.frame_end;

  `XCPD_ASSERT_NOW(a_end_marks_close, clk, rst_n, out_valid_r, out_res_r.frame_end == (out_res_r.kind != K_PAYLOAD), "frame_end disagrees with kind")
  `XCPD_ASSERT_NOW(a_byte_only_payload, clk, rst_n, out_valid_r && (out_res_r.kind != K_PAYLOAD), out_res_r.payload_byte == 8'd0, "payload_byte set on closing result")
  `XCPD_ASSERT_NOW(a_silent_item_moves, clk, rst_n, s1_valid_r && !has_res, advance, "item without result held in input register")
  `XCPD_ASSERT_NEXT(a_result_captured, clk, rst_n, advance && has_res, out_valid_r, "result lost on its way to the output register")

endmodule

// ===== rtl/core/xcpd_step.sv =====
// Frame state of the deframer and the per-item update logic.
// Depends on xcpd_pkg.
module xcpd_step
  import xcpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  item_t       item,
  input  logic [15:0] timeout_ms,
  output logic        has_res,
  output result_t     res
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [15:0] ticks_r, ticks_nxt;

  logic [15:0] ticks_inc;
  logic [7:0]  rem_dec;
  logic [7:0]  xor_in;
  logic [7:0]  b;

  assign b         = item.rx_byte;
  assign ticks_inc = (ticks_r == TICKS_MAX) ? ticks_r : ticks_r + 16'd1;
  assign rem_dec   = (rem_r != 8'd0) ? rem_r - 8'd1 : rem_r;
  assign xor_in    = xor_r ^ b;

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    xor_nxt   = xor_r;
    ticks_nxt = ticks_r;
    has_res   = 1'b0;
    res.kind          = K_PAYLOAD;
    res.frame_command = cmd_r;
    res.payload_byte  = 8'd0;
    res.payload_count = len_r;
    res.frame_end     = 1'b0;

    if (item.opcode == OP_TICK) begin
      if (phase_r != PH_IDLE) begin
        if (ticks_inc >= timeout_ms) begin
          phase_nxt     = PH_IDLE;
          ticks_nxt     = 16'd0;
          has_res       = 1'b1;
          res.kind      = K_TIMEOUT;
          res.frame_end = 1'b1;
        end else begin
          ticks_nxt = ticks_inc;
        end
      end
    end else begin
      ticks_nxt = 16'd0;
      case (phase_r)
        PH_IDLE: begin
          cmd_nxt   = b;
          len_nxt   = 8'd0;
          rem_nxt   = 8'd0;
          xor_nxt   = b;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          if (b < 8'(CONTROL_BYTES)) begin
            len_nxt           = 8'd0;
            rem_nxt           = 8'd0;
            phase_nxt         = PH_IDLE;
            has_res           = 1'b1;
            res.kind          = K_LENERR;
            res.payload_count = 8'd0;
            res.frame_end     = 1'b1;
          end else begin
            xor_nxt   = xor_in;
            len_nxt   = b - 8'(CONTROL_BYTES);
            rem_nxt   = b - 8'(CONTROL_BYTES);
            phase_nxt = (b != 8'(CONTROL_BYTES)) ? PH_PAYLOAD : PH_CHECK;
          end
        end
        PH_PAYLOAD: begin
          xor_nxt = xor_in;
          rem_nxt = rem_dec;
          if (rem_dec == 8'd0) begin
            phase_nxt = PH_CHECK;
          end
          has_res          = 1'b1;
          res.payload_byte = b;
        end
        default: begin
          // checksum byte: the xor over the whole frame must come out zero
          xor_nxt       = xor_in;
          phase_nxt     = PH_IDLE;
          has_res       = 1'b1;
          res.kind      = (xor_in == 8'd0) ? K_OK : K_BAD;
          res.frame_end = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cmd_r   <= 8'd0;
      len_r   <= 8'd0;
      rem_r   <= 8'd0;
      xor_r   <= 8'd0;
      ticks_r <= 16'd0;
    end else if (en) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      rem_r   <= rem_nxt;
      xor_r   <= xor_nxt;
      ticks_r <= ticks_nxt;
    end
  end

endmodule
